// File: design/cspk_pkg.sv
// ----------------------------------------------------------------------------
// cspk_pkg
// Shared types and constants of the cardinal spline key-frame interpolator.
// ----------------------------------------------------------------------------
package cspk_pkg;

    // Operand and result width of the shared multiply unit.
    localparam int unsigned MUL_W  = 36;
    localparam int unsigned MUL_HW = 18;

    // One in unsigned Q1.16, used as the clamp of every quotient.
    localparam logic [16:0] Q_ONE = 17'h10000;

    // Shift codes of the multiply unit.
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_16 = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FEW     = 3'd1;
    localparam logic [2:0] STAT_BEFORE  = 3'd2;
    localparam logic [2:0] STAT_AFTER   = 3'd3;
    localparam logic [2:0] STAT_WRITTEN = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_KEY_COUNT = 1'b0;
    localparam logic CFG_TENSION   = 1'b1;

    localparam logic FUNC_WRITE = 1'b0;

    typedef struct packed {
        logic               func;
        logic [5:0]         key_index;
        logic [31:0]        key_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        query_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [2:0]         status;
    } t_out;

    // One table entry as held in the key memory.
    typedef struct packed {
        logic [31:0] ktime;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
    } t_key;

    typedef struct packed {
        logic              start;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
        logic [1:0]        sh;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic signed [MUL_W-1:0] res;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [16:0] quo;
    } t_div_rsp;

endpackage

// File: design/cspk_ram.sv
// ----------------------------------------------------------------------------
// cspk_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cspk_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/cspk_div.sv
// ----------------------------------------------------------------------------
// cspk_div
// Restoring divider giving min(num * 2^16 / den, 1.0) in unsigned Q1.16,
// one quotient bit per cycle. The caller guarantees a nonzero divisor.
// ----------------------------------------------------------------------------
module cspk_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cspk_pkg::t_div_req  i_req,
    output cspk_pkg::t_div_rsp  o_rsp
);

    localparam logic [4:0] DIV_STEPS = 5'd16;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [16:0] r_quo;

    logic [32:0] w_rem2;
    logic        w_fit;

    assign w_rem2 = {r_rem[31:0], 1'b0};
    assign w_fit  = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.num >= i_req.den) begin
                    // The ratio reaches one and is clamped there.
                    r_quo  <= cspk_pkg::Q_ONE;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {1'b0, i_req.num};
                    r_den  <= i_req.den;
                    r_quo  <= '0;
                    r_cnt  <= DIV_STEPS;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_fit ? (w_rem2 - {1'b0, r_den}) : w_rem2;
                r_quo <= {r_quo[15:0], w_fit};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// File: design/cspk_mul.sv
// ----------------------------------------------------------------------------
// cspk_mul
// Shared sign-magnitude multiplier: (a * b) >> sh, truncated toward zero.
// The product is built from two 36x18 partial products, low half first.
// ----------------------------------------------------------------------------
module cspk_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cspk_pkg::t_mul_req  i_req,
    output cspk_pkg::t_mul_rsp  o_rsp
);

    localparam int unsigned MW = cspk_pkg::MUL_W;
    localparam int unsigned HW = cspk_pkg::MUL_HW;

    logic [1:0]         r_phase;
    logic               r_done;
    logic [MW-1:0]      r_ma;
    logic [MW-1:0]      r_mb;
    logic               r_neg;
    logic [1:0]         r_sh;
    logic [2*MW-1:0]    r_prod;
    logic signed [MW-1:0] r_res;

    logic [MW-1:0]      w_abs_a;
    logic [MW-1:0]      w_abs_b;
    logic [HW-1:0]      w_mb_sel;
    logic [MW+HW-1:0]   w_pp;
    logic [MW-1:0]      w_shifted;

    assign w_abs_a  = i_req.a[MW-1] ? (MW'(0) - MW'(i_req.a)) : MW'(i_req.a);
    assign w_abs_b  = i_req.b[MW-1] ? (MW'(0) - MW'(i_req.b)) : MW'(i_req.b);
    assign w_mb_sel = (r_phase == 2'd1) ? r_mb[HW-1:0] : r_mb[MW-1:HW];
    assign w_pp     = r_ma * w_mb_sel;

    always_comb begin
        unique case (r_sh)
            cspk_pkg::SH_16: w_shifted = r_prod[MW+15:16];
            cspk_pkg::SH_32: w_shifted = r_prod[MW+31:32];
            default:         w_shifted = r_prod[MW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                2'd0: begin
                    if (i_req.start) begin
                        r_ma    <= w_abs_a;
                        r_mb    <= w_abs_b;
                        r_neg   <= i_req.a[MW-1] ^ i_req.b[MW-1];
                        r_sh    <= i_req.sh;
                        r_phase <= 2'd1;
                    end
                end
                2'd1: begin
                    r_prod  <= (2*MW)'(w_pp);
                    r_phase <= 2'd2;
                end
                2'd2: begin
                    r_prod  <= r_prod + ((2*MW)'(w_pp) << HW);
                    r_phase <= 2'd3;
                end
                default: begin
                    r_res   <= r_neg ? $signed(MW'(0) - w_shifted) : $signed(w_shifted);
                    r_done  <= 1'b1;
                    r_phase <= 2'd0;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// File: design/cardinal_spline_keyframe_interp_core.sv
// ----------------------------------------------------------------------------
// cardinal_spline_keyframe_interp_core
// Key-frame table with cardinal Hermite spline evaluation in fixed point.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------
//   in      | to core   | i_in_valid / o_in_stall    | i_in_data  (t_in)
//   out     | from core | o_out_valid / i_out_stall  | o_out_data (t_out)
//   cfg     | to core   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item is worked on at a time. A key write goes straight to its result.
// An evaluate runs a linear search over the key memory, three quotients
// of 16 steps in the divider and 26 products in the shared multiplier.
// A quotient that clamps to one or is skipped takes no divider steps.
// A finished result waits in the output register while the next item runs.
// Reset is synchronous; it clears control state and restores the registers.
// ----------------------------------------------------------------------------
module cardinal_spline_keyframe_interp_core #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cspk_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cspk_pkg::t_out    o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    localparam int unsigned AW = $clog2(MAX_KEYS);
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);
    localparam int unsigned XW = CW + 1;
    localparam int unsigned NW = (CW > 7) ? CW : 7;
    localparam int unsigned IW = (AW > 6) ? AW : 6;
    localparam int unsigned MW = cspk_pkg::MUL_W;
    localparam int unsigned SW = MW + 2;

    localparam logic [3:0] OP_S2 = 4'd0;
    localparam logic [3:0] OP_S3 = 4'd1;
    localparam logic [3:0] OP_T1 = 4'd2;
    localparam logic [3:0] OP_M1 = 4'd3;
    localparam logic [3:0] OP_T2 = 4'd4;
    localparam logic [3:0] OP_M2 = 4'd5;
    localparam logic [3:0] OP_H0 = 4'd6;
    localparam logic [3:0] OP_H1 = 4'd7;
    localparam logic [3:0] OP_H2 = 4'd8;
    localparam logic [3:0] OP_H3 = 4'd9;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_CHK    = 14'b00000000000010,
        ST_RFIRST = 14'b00000000000100,
        ST_RLAST  = 14'b00000000001000,
        ST_SRCH   = 14'b00000000010000,
        ST_SCMP   = 14'b00000000100000,
        ST_FETCH  = 14'b00000001000000,
        ST_DSTART = 14'b00000010000000,
        ST_DWAIT  = 14'b00000100000000,
        ST_MSTART = 14'b00001000000000,
        ST_MWAIT  = 14'b00010000000000,
        ST_HB     = 14'b00100000000000,
        ST_DONE   = 14'b01000000000000,
        ST_SPARE  = 14'b10000000000000
    } t_state;

    t_state              r_state;
    logic [6:0]          r_key_count;
    logic [15:0]         r_tension;
    logic                r_out_vld;
    cspk_pkg::t_out      r_out_data;
    logic [31:0]         r_q;
    logic [CW-1:0]       r_n;
    logic [AW-1:0]       r_k;
    logic [2:0]          r_cnt;
    logic [1:0]          r_dsel;
    logic [3:0]          r_op;
    logic [1:0]          r_axis;
    logic [2:0]          r_stat;
    cspk_pkg::t_key      r_key [4];
    logic [16:0]         r_s;
    logic [16:0]         r_r1;
    logic [16:0]         r_r2;
    logic signed [MW-1:0] r_s2;
    logic signed [MW-1:0] r_s3;
    logic signed [MW-1:0] r_tmp;
    logic signed [MW-1:0] r_m1;
    logic signed [MW-1:0] r_m2;
    logic signed [MW-1:0] r_h [4];
    logic signed [SW-1:0] r_acc;
    logic signed [31:0]  r_xyz [3];

    logic                w_in_acc;
    logic                w_we;
    logic [IW-1:0]       w_idx_ext;
    logic [NW-1:0]       w_kc_ext;
    logic [NW-1:0]       w_n_ext;
    logic [AW-1:0]       w_raddr;
    cspk_pkg::t_key      w_wkey;
    cspk_pkg::t_key      w_rkey;
    logic [127:0]        w_rdata;
    logic [XW-1:0]       w_k2;
    logic                w_more;
    logic [AW-1:0]       w_k1;
    logic [CW-1:0]       w_nm1_c;
    logic [AW-1:0]       w_nm1;
    logic [AW-1:0]       w_i0;
    logic [AW-1:0]       w_i3;
    logic [1:0]          w_slot;
    logic                w_lenpos;
    logic [31:0]         w_len;
    logic                w_div_ok;
    cspk_pkg::t_div_req  w_div_req;
    cspk_pkg::t_div_rsp  w_div_rsp;
    cspk_pkg::t_mul_req  w_mul_req;
    cspk_pkg::t_mul_rsp  w_mul_rsp;
    logic signed [31:0]  w_p [4];
    logic signed [SW-1:0] w_sum;
    logic signed [31:0]  w_sat;
    logic signed [SW-1:0] w_hs;
    logic signed [SW-1:0] w_hs2;
    logic signed [SW-1:0] w_hs3;

    // ------------------------------------------------------------------
    // Handshakes and configuration
    // ------------------------------------------------------------------
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= 7'd0;
            r_tension   <= 16'h8000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cspk_pkg::CFG_KEY_COUNT: r_key_count <= i_cfg_data[6:0];
                cspk_pkg::CFG_TENSION:   r_tension   <= i_cfg_data;
                default:                 r_tension   <= r_tension;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Key memory
    // ------------------------------------------------------------------
    assign w_idx_ext = IW'(i_in_data.key_index);
    assign w_we      = w_in_acc && (i_in_data.func == cspk_pkg::FUNC_WRITE)
                       && (32'(w_idx_ext) < 32'(MAX_KEYS));
    assign w_wkey.ktime = i_in_data.key_time;
    assign w_wkey.kx    = i_in_data.pos_x;
    assign w_wkey.ky    = i_in_data.pos_y;
    assign w_wkey.kz    = i_in_data.pos_z;
    assign w_rkey       = cspk_pkg::t_key'(w_rdata);

    cspk_ram #(
        .WIDTH (128),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx_ext[AW-1:0]),
        .i_wdata (w_wkey),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Index arithmetic
    // ------------------------------------------------------------------
    assign w_kc_ext = NW'(r_key_count);
    assign w_n_ext  = (w_kc_ext > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : w_kc_ext;
    assign w_k2     = XW'(r_k) + XW'(2);
    assign w_more   = (w_k2 < XW'(r_n));
    assign w_k1     = r_k + AW'(1);
    assign w_nm1_c  = r_n - CW'(1);
    assign w_nm1    = w_nm1_c[AW-1:0];
    assign w_i0     = (r_k == '0) ? '0 : (r_k - AW'(1));
    assign w_i3     = w_more ? w_k2[AW-1:0] : w_nm1;
    assign w_slot   = 2'(r_cnt - 3'd1);

    always_comb begin
        priority case (1'b1)
            (r_state == ST_RFIRST): w_raddr = w_nm1;
            (r_state == ST_SRCH):   w_raddr = w_k1;
            (r_state == ST_FETCH) && (r_cnt[1:0] == 2'd1): w_raddr = r_k;
            (r_state == ST_FETCH) && (r_cnt[1:0] == 2'd2): w_raddr = w_k1;
            (r_state == ST_FETCH) && (r_cnt[1:0] == 2'd3): w_raddr = w_i3;
            (r_state == ST_FETCH): w_raddr = w_i0;
            default:                w_raddr = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Divider operands: s, then the two tangent time ratios
    // ------------------------------------------------------------------
    assign w_lenpos = (r_key[2].ktime > r_key[1].ktime);
    assign w_len    = r_key[2].ktime - r_key[1].ktime;

    always_comb begin
        w_div_req.num = w_len;
        unique case (r_dsel)
            2'd0: begin
                w_div_ok      = w_lenpos && (r_q > r_key[1].ktime);
                w_div_req.num = r_q - r_key[1].ktime;
                w_div_req.den = w_len;
            end
            2'd1: begin
                w_div_ok      = w_lenpos && (r_key[2].ktime > r_key[0].ktime);
                w_div_req.den = r_key[2].ktime - r_key[0].ktime;
            end
            default: begin
                w_div_ok      = w_lenpos && (r_key[3].ktime > r_key[1].ktime);
                w_div_req.den = r_key[3].ktime - r_key[1].ktime;
            end
        endcase
        w_div_req.start = (r_state == ST_DSTART) && w_div_ok;
    end

    cspk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // Multiplier operands
    // ------------------------------------------------------------------
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            unique case (r_axis)
                2'd0:    w_p[j] = $signed(r_key[j].kx);
                2'd1:    w_p[j] = $signed(r_key[j].ky);
                default: w_p[j] = $signed(r_key[j].kz);
            endcase
        end
    end

    always_comb begin
        w_mul_req.start = (r_state == ST_MSTART);
        w_mul_req.sh    = cspk_pkg::SH_16;
        w_mul_req.a     = r_tmp;
        w_mul_req.b     = $signed(MW'({r_tension, 1'b0}));
        unique case (r_op)
            OP_S2: begin
                w_mul_req.a  = $signed(MW'(r_s));
                w_mul_req.b  = $signed(MW'(r_s));
                w_mul_req.sh = cspk_pkg::SH_0;
            end
            OP_S3: begin
                w_mul_req.a = r_s2;
                w_mul_req.b = $signed(MW'(r_s));
            end
            OP_T1: begin
                w_mul_req.a = MW'(w_p[2]) - MW'(w_p[0]);
                w_mul_req.b = $signed(MW'(r_r1));
            end
            OP_T2: begin
                w_mul_req.a = MW'(w_p[3]) - MW'(w_p[1]);
                w_mul_req.b = $signed(MW'(r_r2));
            end
            OP_H0: begin
                w_mul_req.a  = r_h[0];
                w_mul_req.b  = MW'(w_p[1]);
                w_mul_req.sh = cspk_pkg::SH_32;
            end
            OP_H1: begin
                w_mul_req.a  = r_h[1];
                w_mul_req.b  = r_m1;
                w_mul_req.sh = cspk_pkg::SH_32;
            end
            OP_H2: begin
                w_mul_req.a  = r_h[2];
                w_mul_req.b  = MW'(w_p[2]);
                w_mul_req.sh = cspk_pkg::SH_32;
            end
            OP_H3: begin
                w_mul_req.a  = r_h[3];
                w_mul_req.b  = r_m2;
                w_mul_req.sh = cspk_pkg::SH_32;
            end
            default: begin
                w_mul_req.a = r_tmp;
            end
        endcase
    end

    cspk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign w_sum = r_acc + SW'(w_mul_rsp.res);
    assign w_sat = (w_sum > SW'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                   (w_sum < SW'(-33'sh8000_0000)) ? 32'sh8000_0000 : w_sum[31:0];

    // Hermite basis operands, widened so the sums cannot wrap.
    assign w_hs  = $signed(SW'(r_s));
    assign w_hs2 = SW'(r_s2);
    assign w_hs3 = SW'(r_s3);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_q <= i_in_data.query_time;
                        r_n <= w_n_ext[CW-1:0];
                        if (i_in_data.func == cspk_pkg::FUNC_WRITE) begin
                            r_stat  <= cspk_pkg::STAT_WRITTEN;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_CHK;
                        end
                    end
                end
                ST_CHK: begin
                    // Entry zero is being read here.
                    if (r_n < CW'(2)) begin
                        r_stat  <= cspk_pkg::STAT_FEW;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_RFIRST;
                    end
                end
                ST_RFIRST: begin
                    if (r_q < w_rkey.ktime) begin
                        r_stat  <= cspk_pkg::STAT_BEFORE;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_RLAST;
                    end
                end
                ST_RLAST: begin
                    if (r_q > w_rkey.ktime) begin
                        r_stat  <= cspk_pkg::STAT_AFTER;
                        r_state <= ST_DONE;
                    end else begin
                        r_k     <= '0;
                        r_state <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (w_more) begin
                        r_state <= ST_SCMP;
                    end else begin
                        r_cnt   <= 3'd0;
                        r_state <= ST_FETCH;
                    end
                end
                ST_SCMP: begin
                    if (w_rkey.ktime < r_q) begin
                        r_k     <= w_k1;
                        r_state <= ST_SRCH;
                    end else begin
                        r_cnt   <= 3'd0;
                        r_state <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    if (r_cnt != 3'd0) begin
                        r_key[w_slot] <= w_rkey;
                    end
                    if (r_cnt == 3'd4) begin
                        r_dsel  <= 2'd0;
                        r_state <= ST_DSTART;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                ST_DSTART: begin
                    if (w_div_ok) begin
                        r_state <= ST_DWAIT;
                    end else begin
                        // A zero ratio gives s of zero or a zero tangent.
                        unique case (r_dsel)
                            2'd0:    r_s  <= '0;
                            2'd1:    r_r1 <= '0;
                            default: r_r2 <= '0;
                        endcase
                        if (r_dsel == 2'd2) begin
                            r_op    <= OP_S2;
                            r_axis  <= 2'd0;
                            r_state <= ST_MSTART;
                        end else begin
                            r_dsel <= r_dsel + 2'd1;
                        end
                    end
                end
                ST_DWAIT: begin
                    if (w_div_rsp.done) begin
                        unique case (r_dsel)
                            2'd0:    r_s  <= w_div_rsp.quo;
                            2'd1:    r_r1 <= w_div_rsp.quo;
                            default: r_r2 <= w_div_rsp.quo;
                        endcase
                        if (r_dsel == 2'd2) begin
                            r_op    <= OP_S2;
                            r_axis  <= 2'd0;
                            r_state <= ST_MSTART;
                        end else begin
                            r_dsel  <= r_dsel + 2'd1;
                            r_state <= ST_DSTART;
                        end
                    end
                end
                ST_MSTART: begin
                    r_state <= ST_MWAIT;
                end
                ST_MWAIT: begin
                    if (w_mul_rsp.done) begin
                        r_state <= ST_MSTART;
                        r_op    <= r_op + 4'd1;
                        unique case (r_op)
                            OP_S2: r_s2 <= w_mul_rsp.res;
                            OP_S3: begin
                                r_s3    <= w_mul_rsp.res;
                                r_state <= ST_HB;
                            end
                            OP_T1, OP_T2: r_tmp <= w_mul_rsp.res;
                            OP_M1: r_m1 <= w_mul_rsp.res;
                            OP_M2: r_m2 <= w_mul_rsp.res;
                            OP_H0: r_acc <= SW'(w_mul_rsp.res);
                            OP_H3: begin
                                r_xyz[r_axis] <= w_sat;
                                r_op          <= OP_T1;
                                if (r_axis == 2'd2) begin
                                    r_stat  <= cspk_pkg::STAT_OK;
                                    r_state <= ST_DONE;
                                end else begin
                                    r_axis <= r_axis + 2'd1;
                                end
                            end
                            default: r_acc <= w_sum;
                        endcase
                    end
                end
                ST_HB: begin
                    r_h[0] <= MW'((w_hs3 <<< 1) - (w_hs2 + (w_hs2 <<< 1))
                                  + SW'(38'sh01_0000_0000));
                    r_h[1] <= MW'(w_hs3 - (w_hs2 <<< 1) + (w_hs <<< 16));
                    r_h[2] <= MW'((w_hs2 + (w_hs2 <<< 1)) - (w_hs3 <<< 1));
                    r_h[3] <= MW'(w_hs3 - w_hs2);
                    r_op    <= OP_T1;
                    r_state <= ST_MSTART;
                end
                ST_DONE: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld         <= 1'b1;
                        r_out_data.status <= r_stat;
                        if (r_stat == cspk_pkg::STAT_OK) begin
                            r_out_data.out_x <= r_xyz[0];
                            r_out_data.out_y <= r_xyz[1];
                            r_out_data.out_z <= r_xyz[2];
                        end else begin
                            r_out_data.out_x <= '0;
                            r_out_data.out_y <= '0;
                            r_out_data.out_z <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("second transfer taken while an item is in progress");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == ST_MWAIT))
        else $error("multiplier finished outside a wait state");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DWAIT))
        else $error("divider finished outside a wait state");

    a_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DSTART) |-> (w_k2 <= XW'(r_n)))
        else $error("interval index beyond the last key");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cardinal spline key-frame interpolator testbench
// Loads key tables, evaluates the spline at chosen times under several key
// counts and tensions, and checks every result against a fixed-point
// predictor of the core, with random gaps and back-pressure on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NKEYS = 64;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            o_in_stall;
    cspk_pkg::t_in   in_data = '0;
    logic            o_out_valid;
    logic            out_stall = 1'b0;
    cspk_pkg::t_out  o_out_data;
    logic            cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic            cfg_index = cspk_pkg::CFG_KEY_COUNT;
    logic [15:0]     cfg_data = '0;

    cardinal_spline_keyframe_interp_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: the key table and the two registers.
    logic [31:0]        key_t [NKEYS];
    logic signed [31:0] key_x [NKEYS];
    logic signed [31:0] key_y [NKEYS];
    logic signed [31:0] key_z [NKEYS];
    logic [6:0]         cur_count = 7'd0;
    logic [15:0]        cur_tension = 16'd32768;

    cspk_pkg::t_in  pending_items[$];
    cspk_pkg::t_out expected_points[$];
    bit   quiet = 1'b0;
    int   mismatches = 0;
    int   item_total = 0;
    logic [31:0] gen_time [NKEYS];

    function automatic longint mul_trunc(longint a, longint b, int sh);
        logic neg;
        longint unsigned ma, mb, q;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        q = (ma * mb) >> sh;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint key_tangent(longint pa, longint pb, longint len, longint span);
        longint r;
        if (len <= 0 || span <= 0) return 0;
        r = (len * 65536) / span;
        if (r > 65536) r = 65536;
        return mul_trunc(mul_trunc(pb - pa, r, 16), longint'(cur_tension) * 2, 16);
    endfunction

    function automatic logic [31:0] hermite_axis(logic signed [31:0] q0, logic signed [31:0] q1,
                                                 logic signed [31:0] q2, logic signed [31:0] q3,
                                                 longint len, longint span1, longint span2,
                                                 longint h0, longint h1, longint h2, longint h3);
        longint m1, m2, sum;
        m1 = key_tangent(longint'(q0), longint'(q2), len, span1);
        m2 = key_tangent(longint'(q1), longint'(q3), len, span2);
        sum = mul_trunc(h0, longint'(q1), 32) + mul_trunc(h1, m1, 32)
            + mul_trunc(h2, longint'(q2), 32) + mul_trunc(h3, m2, 32);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    // Applies one accepted item to the predictor and returns its result.
    function automatic cspk_pkg::t_out spline_predict(cspk_pkg::t_in it);
        cspk_pkg::t_out r;
        int     n, k, i0, i3;
        longint t0, t1, t2, t3, len, s, s2, s3, d, h0, h1, h2, h3;
        r = '0;
        if (it.func == cspk_pkg::FUNC_WRITE) begin
            key_t[it.key_index] = it.key_time;
            key_x[it.key_index] = it.pos_x;
            key_y[it.key_index] = it.pos_y;
            key_z[it.key_index] = it.pos_z;
            r.status = cspk_pkg::STAT_WRITTEN;
            return r;
        end
        n = (cur_count > NKEYS) ? NKEYS : cur_count;
        if (n < 2) begin
            r.status = cspk_pkg::STAT_FEW;
            return r;
        end
        if (it.query_time < key_t[0]) begin
            r.status = cspk_pkg::STAT_BEFORE;
            return r;
        end
        if (it.query_time > key_t[n-1]) begin
            r.status = cspk_pkg::STAT_AFTER;
            return r;
        end
        k = 0;
        while (k + 2 < n && key_t[k+1] < it.query_time) k++;
        i0 = (k == 0) ? 0 : k - 1;
        i3 = (k + 2 > n - 1) ? n - 1 : k + 2;
        t0 = longint'(key_t[i0]);
        t1 = longint'(key_t[k]);
        t2 = longint'(key_t[k+1]);
        t3 = longint'(key_t[i3]);
        len = t2 - t1;
        if (len <= 0) begin
            s = 0;
            len = 0;
        end else begin
            d = longint'(it.query_time) - t1;
            s = (d <= 0) ? 0 : (d * 65536) / len;
            if (s > 65536) s = 65536;
        end
        s2 = s * s;
        s3 = (s2 * s) >> 16;
        h0 = 2 * s3 - 3 * s2 + 64'sd4294967296;
        h1 = s3 - 2 * s2 + s * 65536;
        h2 = 3 * s2 - 2 * s3;
        h3 = s3 - s2;
        r.out_x = hermite_axis(key_x[i0], key_x[k], key_x[k+1], key_x[i3],
                               len, t2 - t0, t3 - t1, h0, h1, h2, h3);
        r.out_y = hermite_axis(key_y[i0], key_y[k], key_y[k+1], key_y[i3],
                               len, t2 - t0, t3 - t1, h0, h1, h2, h3);
        r.out_z = hermite_axis(key_z[i0], key_z[k], key_z[k+1], key_z[i3],
                               len, t2 - t0, t3 - t1, h0, h1, h2, h3);
        r.status = cspk_pkg::STAT_OK;
        return r;
    endfunction

    // Input driver: a new item goes out once the previous transfer has happened.
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) expected_points.push_back(spline_predict(in_data));
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 16);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and back-pressure.
    int stall_left = 0;
    always @(posedge i_clk) begin
        cspk_pkg::t_out exp_pt;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_out_data);
            end else begin
                exp_pt = expected_points.pop_front();
                if (o_out_data.out_x !== exp_pt.out_x || o_out_data.out_y !== exp_pt.out_y ||
                    o_out_data.out_z !== exp_pt.out_z || o_out_data.status !== exp_pt.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
                                 exp_pt.out_x, exp_pt.out_y, exp_pt.out_z, exp_pt.status,
                                 o_out_data.out_x, o_out_data.out_y, o_out_data.out_z,
                                 o_out_data.status);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
        end
    end

    function automatic cspk_pkg::t_in key_write(int idx, logic [31:0] t, logic [31:0] x,
                                                logic [31:0] y, logic [31:0] z);
        cspk_pkg::t_in it;
        it.func = cspk_pkg::FUNC_WRITE;
        it.key_index = idx[5:0];
        it.key_time = t;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.query_time = $urandom;
        return it;
    endfunction

    function automatic cspk_pkg::t_in key_eval(logic [31:0] q);
        cspk_pkg::t_in it;
        it.func = ~cspk_pkg::FUNC_WRITE;
        it.key_index = $urandom;
        it.key_time = $urandom;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        it.query_time = q;
        return it;
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
        endcase
    endfunction

    task automatic push_item(cspk_pkg::t_in it);
        pending_items.push_back(it);
        item_total++;
    endtask

    // Table shapes: 0 ascending, 1 with repeated times, 2 unsorted, 3 spanning
    // the whole time range.
    task automatic load_table(int n, int shape);
        longint t;
        t = (shape == 3) ? 0 : $urandom_range(0, 4096);
        for (int i = 0; i < n; i++) begin
            case (shape)
                2: gen_time[i] = $urandom;
                3: gen_time[i] = (i == n - 1) ? 32'hFFFF_FFFF : t[31:0];
                default: gen_time[i] = t[31:0];
            endcase
            if (shape == 1 && $urandom_range(0, 2) == 0) t = t;
            else if (shape == 3) t = t + $urandom_range(1, 32'h0FFF_FFFF) / (n > 1 ? n : 1) + 1;
            else t = t + $urandom_range(1, 32'h0010_0000);
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            push_item(key_write(i, gen_time[i], rand_pos(), rand_pos(), rand_pos()));
        end
    endtask

    task automatic add_queries(int n, int count);
        logic [31:0] q, lo, hi;
        for (int c = 0; c < count; c++) begin
            if (n < 2) begin
                q = $urandom;
            end else begin
                lo = gen_time[0];
                hi = gen_time[n-1];
                case ($urandom_range(0, 9))
                    0: q = (lo == 0) ? lo : lo - 1;
                    1: q = (hi == 32'hFFFF_FFFF) ? hi : hi + 1;
                    2: q = gen_time[$urandom_range(0, n - 1)];
                    3: q = $urandom;
                    4: q = lo;
                    5: q = hi;
                    default: q = (hi > lo) ? lo + $urandom_range(0, hi - lo) : lo;
                endcase
            end
            push_item(key_eval(q));
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || in_valid || expected_points.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == cspk_pkg::CFG_KEY_COUNT) cur_count = value[6:0];
        else cur_tension = value;
        @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int tens, int shape, int queries);
        int n;
        wait_idle();
        reg_write(cspk_pkg::CFG_KEY_COUNT, {9'($urandom), 7'(count)});
        reg_write(cspk_pkg::CFG_TENSION, 16'(tens));
        n = (count > NKEYS) ? NKEYS : count;
        if (n >= 2) load_table(n, shape);
        add_queries(n, queries);
    endtask

    initial begin
        int kc;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // No keys yet: evaluate reports too few keys, then every slot gets written.
        add_queries(0, 2);
        load_table(NKEYS, 0);
        run_phase(1, 32768, 0, 2);
        run_phase(2, 0, 0, 8);
        run_phase(3, 65535, 1, 8);
        run_phase(2, 65535, 1, 4);
        run_phase(64, 32768, 3, 10);
        run_phase(127, 12345, 2, 10);
        while (item_total < 360) begin
            case ($urandom_range(0, 9))
                0: kc = $urandom_range(0, 1);
                1: kc = NKEYS;
                2: kc = $urandom_range(65, 127);
                default: kc = $urandom_range(2, 10);
            endcase
            run_phase(kc, ($urandom_range(0, 3) == 0) ? 65535 * $urandom_range(0, 1)
                                                       : $urandom_range(0, 65535),
                      $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3),
                      $urandom_range(10, 25));
        end
        wait_idle();
        quiet = 1'b1;
        run_phase($urandom_range(3, 8), $urandom_range(0, 65535), 0, 30);
        wait_idle();
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
